>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the next clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mle_pkg.sv
// Package: types, opcodes, function codes and fault codes for the execute unit.
package mle_pkg;

  localparam int unsigned MemWords   = 4096;
  localparam int unsigned MemAw      = $clog2(MemWords);
  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] OpRtype = 7'd0;
  localparam logic [6:0] OpBltz  = 7'd1;
  localparam logic [6:0] OpJ     = 7'd2;
  localparam logic [6:0] OpJal   = 7'd3;
  localparam logic [6:0] OpBeq   = 7'd4;
  localparam logic [6:0] OpBne   = 7'd5;
  localparam logic [6:0] OpAndi  = 7'd6;
  localparam logic [6:0] OpBgtz  = 7'd7;
  localparam logic [6:0] OpAddi  = 7'd8;
  localparam logic [6:0] OpOri   = 7'd13;
  localparam logic [6:0] OpLw    = 7'd67;
  localparam logic [6:0] OpSw    = 7'd75;
  localparam logic [6:0] OpOut   = 7'd125;
  localparam logic [6:0] OpIn    = 7'd126;
  localparam logic [6:0] OpHalt  = 7'd127;

  localparam logic [6:0] FnSll  = 7'd0;
  localparam logic [6:0] FnSrl  = 7'd2;
  localparam logic [6:0] FnJr   = 7'd8;
  localparam logic [6:0] FnMult = 7'd40;
  localparam logic [6:0] FnAdd  = 7'd64;
  localparam logic [6:0] FnSub  = 7'd66;
  localparam logic [6:0] FnAnd  = 7'd68;
  localparam logic [6:0] FnOr   = 7'd69;
  localparam logic [6:0] FnXor  = 7'd72;
  localparam logic [6:0] FnDiv  = 7'd74;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultDiv0 = 2'd1;
  localparam logic [1:0] FaultAddr = 2'd2;
  localparam logic [1:0] FaultOp   = 2'd3;

  // Operation classes decided by the front end.
  typedef enum logic [3:0] {
    K_ALU, K_SLL, K_SRL, K_MUL, K_DIV, K_JR, K_ADDI, K_ANDI, K_ORI,
    K_LW, K_SW, K_BR, K_JMP, K_JAL, K_IN, K_OUT
  } kind_t;

  typedef struct packed {
    logic [6:0]  opcode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [4:0]  shift_amount;
    logic [6:0]  function_code;
    logic signed [31:0] immediate;
    logic [31:0] pc_value;
    logic signed [31:0] in_value;
  } item_t;

  typedef struct packed {
    logic        jump_taken;
    logic signed [31:0] jump_target;
    logic        out_valid;
    logic signed [31:0] out_value;
    logic        halted;
    logic [1:0]  fault;
  } result_t;

  // Classified entry passed from front to back.
  typedef struct packed {
    kind_t       kind;
    logic        halt;
    logic        bad;
    logic [6:0]  opcode;
    logic [6:0]  function_code;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [4:0]  shift_amount;
    logic [31:0] immediate;
    logic [31:0] pc_value;
    logic [31:0] in_value;
  } uop_t;

endpackage

>>> rtl/mle_if.sv
// Valid/ready channel interfaces for items and results.
interface mle_item_if (input logic clk);
  logic           valid;
  logic           ready;
  mle_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mle_result_if (input logic clk);
  logic             valid;
  logic             ready;
  mle_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mle_ram.sv
// Generic single-port RAM with registered read.
module mle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/mle_front.sv
// Front end: accept items, classify them and queue them for the back end.
module mle_front (
  input  logic             clk,
  input  logic             rst,
  mle_item_if.sink         in_ch,
  output logic             q_valid,
  input  logic             q_pop,
  output mle_pkg::uop_t    q_head
);
  mle_pkg::uop_t q [mle_pkg::QueueDepth];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  mle_pkg::uop_t dec;
  logic          push;

  always_comb begin
    dec               = '0;
    dec.opcode        = in_ch.data.opcode;
    dec.function_code = in_ch.data.function_code;
    dec.dest_reg      = in_ch.data.dest_reg;
    dec.src_reg       = in_ch.data.src_reg;
    dec.second_reg    = in_ch.data.second_reg;
    dec.shift_amount  = in_ch.data.shift_amount;
    dec.immediate     = in_ch.data.immediate;
    dec.pc_value      = in_ch.data.pc_value;
    dec.in_value      = in_ch.data.in_value;
    dec.kind          = mle_pkg::K_ALU;
    unique case (in_ch.data.opcode)
      mle_pkg::OpRtype: begin
        unique case (in_ch.data.function_code)
          mle_pkg::FnAdd, mle_pkg::FnSub, mle_pkg::FnAnd, mle_pkg::FnOr,
          mle_pkg::FnXor: dec.kind = mle_pkg::K_ALU;
          mle_pkg::FnMult: dec.kind = mle_pkg::K_MUL;
          mle_pkg::FnDiv:  dec.kind = mle_pkg::K_DIV;
          mle_pkg::FnSll:  dec.kind = mle_pkg::K_SLL;
          mle_pkg::FnSrl:  dec.kind = mle_pkg::K_SRL;
          mle_pkg::FnJr:   dec.kind = mle_pkg::K_JR;
          default:         dec.bad  = 1'b1;
        endcase
      end
      mle_pkg::OpAddi: dec.kind = mle_pkg::K_ADDI;
      mle_pkg::OpAndi: dec.kind = mle_pkg::K_ANDI;
      mle_pkg::OpOri:  dec.kind = mle_pkg::K_ORI;
      mle_pkg::OpLw:   dec.kind = mle_pkg::K_LW;
      mle_pkg::OpSw:   dec.kind = mle_pkg::K_SW;
      mle_pkg::OpBeq, mle_pkg::OpBne, mle_pkg::OpBgtz, mle_pkg::OpBltz:
        dec.kind = mle_pkg::K_BR;
      mle_pkg::OpJ:    dec.kind = mle_pkg::K_JMP;
      mle_pkg::OpJal:  dec.kind = mle_pkg::K_JAL;
      mle_pkg::OpIn:   dec.kind = mle_pkg::K_IN;
      mle_pkg::OpOut:  dec.kind = mle_pkg::K_OUT;
      mle_pkg::OpHalt: dec.halt = 1'b1;
      default:         dec.bad  = 1'b1;
    endcase
  end

  assign in_ch.ready = (count != 2'(mle_pkg::QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

>>> rtl/mle_div.sv
// Iterative signed divider, one quotient bit per cycle.
module mle_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem, q, mb;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, q[31]} - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        q    <= a[31] ? (32'd0 - a) : a;
        mb   <= b[31] ? (32'd0 - b) : b;
        neg  <= a[31] ^ b[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? (32'd0 - q) : q;
endmodule

>>> rtl/mle_back.sv
// Back end: register file, memory, multiplier/divider and result register.
module mle_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mle_pkg::uop_t q_head,
  output logic          q_pop,
  mle_result_if.source  out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_DIV, S_MEM, S_OUT} state_t;

  state_t              state;
  state_t              exec_state;
  mle_pkg::uop_t       u;
  logic [31:0]         rf [32];
  logic [31:0]         a, b, sum, addr;
  logic [31:0]         mul_lo;
  logic                div_start, div_done;
  logic [31:0]         div_q;
  logic                mem_we;
  logic [31:0]         mem_rdata;
  logic                addr_ok;
  logic                br_taken;
  mle_pkg::result_t    res;
  mle_pkg::result_t    res_next;

  assign addr    = a + u.immediate;
  assign addr_ok = (addr < 32'(mle_pkg::MemWords));
  assign mem_we  = (state == S_EXEC) && (u.kind == mle_pkg::K_SW) && !u.bad
                   && !u.halt && addr_ok;
  assign sum     = a + b;

  mle_ram #(.Width(32), .Depth(mle_pkg::MemWords)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (addr[mle_pkg::MemAw-1:0]),
    .wdata(b),
    .rdata(mem_rdata)
  );

  mle_div u_div (
    .clk  (clk), .rst(rst), .start(div_start), .a(a), .b(b),
    .done (div_done), .quo(div_q)
  );

  assign div_start = (state == S_EXEC) && (u.kind == mle_pkg::K_DIV) && !u.bad
                     && !u.halt && (b != 32'd0);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;

  // Result fields and follow-on state of the execute cycle.
  always_comb begin
    res_next   = '0;
    exec_state = S_OUT;
    br_taken   = 1'b0;
    if (u.bad) begin
      res_next.fault = mle_pkg::FaultOp;
    end else if (u.halt) begin
      res_next.halted = 1'b1;
    end else begin
      unique case (u.kind)
        mle_pkg::K_MUL: exec_state = S_MUL;
        mle_pkg::K_DIV: begin
          if (b == 32'd0) res_next.fault = mle_pkg::FaultDiv0;
          else exec_state = S_DIV;
        end
        mle_pkg::K_JR: begin
          res_next.jump_taken  = 1'b1;
          res_next.jump_target = a;
        end
        mle_pkg::K_LW: begin
          if (!addr_ok) res_next.fault = mle_pkg::FaultAddr;
          else exec_state = S_MEM;
        end
        mle_pkg::K_SW: begin
          if (!addr_ok) res_next.fault = mle_pkg::FaultAddr;
        end
        mle_pkg::K_BR: begin
          priority if (u.opcode == mle_pkg::OpBeq) begin
            br_taken = (a == b);
          end else if (u.opcode == mle_pkg::OpBne) begin
            br_taken = (a != b);
          end else if (u.opcode == mle_pkg::OpBgtz) begin
            br_taken = !a[31] && (a != 32'd0);
          end else begin
            br_taken = a[31];
          end
          res_next.jump_taken  = br_taken;
          res_next.jump_target = br_taken ? u.immediate : '0;
        end
        mle_pkg::K_JMP, mle_pkg::K_JAL: begin
          res_next.jump_taken  = 1'b1;
          res_next.jump_target = u.immediate;
        end
        mle_pkg::K_OUT: begin
          res_next.out_valid = 1'b1;
          res_next.out_value = a;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 32; i++) rf[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            u     <= q_head;
            a     <= rf[q_head.src_reg];
            b     <= rf[q_head.second_reg];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res   <= res_next;
          state <= exec_state;
          if (!u.bad && !u.halt) begin
            unique case (u.kind)
              mle_pkg::K_ALU: begin
                unique case (u.function_code)
                  mle_pkg::FnAdd: rf[u.dest_reg] <= sum;
                  mle_pkg::FnSub: rf[u.dest_reg] <= a - b;
                  mle_pkg::FnAnd: rf[u.dest_reg] <= a & b;
                  mle_pkg::FnOr:  rf[u.dest_reg] <= a | b;
                  default:        rf[u.dest_reg] <= a ^ b;
                endcase
              end
              mle_pkg::K_SLL: rf[u.dest_reg] <= b << u.shift_amount;
              mle_pkg::K_SRL: rf[u.dest_reg] <= b >> u.shift_amount;
              mle_pkg::K_MUL: mul_lo <= 32'(a * b);
              mle_pkg::K_ADDI: rf[u.second_reg] <= addr;
              mle_pkg::K_ANDI: rf[u.second_reg] <= a & u.immediate;
              mle_pkg::K_ORI:  rf[u.second_reg] <= a | u.immediate;
              mle_pkg::K_JAL:  rf[31] <= u.pc_value;
              mle_pkg::K_IN:   rf[u.src_reg] <= u.in_value;
              default: ;
            endcase
          end
        end
        S_MUL: begin
          rf[u.dest_reg] <= mul_lo;
          state <= S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            rf[u.dest_reg] <= div_q;
            state <= S_OUT;
          end
        end
        S_MEM: begin
          rf[u.second_reg] <= mem_rdata;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/mips_like_execute_unit.sv
// Top level of the execute unit: front end, queue, back end.
//
//  channel   dir   payload            transfer when
//  in_ch     in    mle_pkg::item_t    in_ch.valid && in_ch.ready
//  out_ch    out   mle_pkg::result_t  out_ch.valid && out_ch.ready
//
// Steps per item: queue read, execute and present for most operations;
// MULT and LW add a write-back state, and DIV waits in the divide state,
// one quotient bit a cycle, until the divider signals done.
// The back end runs one item at a time; the front queue holds two more.
// Reset (rst, synchronous) clears the register file and queue pointers;
// data memory is not cleared.
// A stalled out_ch holds the result and the back end; the queue keeps
// taking items until full.
`include "assert_macros.svh"
module mips_like_execute_unit (
  input logic          clk,
  input logic          rst,
  mle_item_if.sink     in_ch,
  mle_result_if.source out_ch
);
  logic          q_valid;
  logic          q_pop;
  mle_pkg::uop_t q_head;

  mle_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  mle_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .out_ch(out_ch)
  );

  // Pop only what is queued.
  `ASSERT_IMPL(a_pop_valid, clk, rst, q_pop, q_valid, "pop from empty queue")
  // No pop while a result waits.
  `ASSERT_IMPL(a_no_pop_out, clk, rst, out_ch.valid, !q_pop, "pop while result pending")
  // A halt result carries no jump and no fault.
  `ASSERT_IMPL(a_halt_clean, clk, rst, out_ch.valid && out_ch.data.halted,
               !out_ch.data.jump_taken && out_ch.data.fault == mle_pkg::FaultNone,
               "halt result malformed")
endmodule

>>> tb/mips_like_execute_unit_test.sv
// Testbench for the execute unit: directed table plus random programs, checked by a predictor.
`timescale 1ns / 100ps
module mips_like_execute_unit_test;

  localparam int WatchdogLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mle_item_if   in_ch  (.clk(clk));
  mle_result_if out_ch (.clk(clk));

  mips_like_execute_unit dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predictor state: register file, data memory and a map of which words were stored.
  logic [31:0] regs_q [32];
  logic [31:0] mem_q [mle_pkg::MemWords];
  bit          mem_written [mle_pkg::MemWords];
  int          written_addrs [$];

  mle_pkg::result_t expected_results [$];
  int      errors = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      faults_seen = 0;
  int      jumps_seen = 0;

  // Signed truncating division at 32 bits; most negative divided by -1 wraps.
  function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? (32'd0 - a) : a;
    mb = b[31] ? (32'd0 - b) : b;
    q = ma / mb;
    return (a[31] != b[31]) ? (32'd0 - q) : q;
  endfunction

  // Execute one instruction on the predictor's state and return its result.
  function automatic mle_pkg::result_t execute_item(mle_pkg::item_t it);
    mle_pkg::result_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] addr;
    logic [mle_pkg::MemAw-1:0] idx;
    a = regs_q[it.src_reg];
    b = regs_q[it.second_reg];
    imm = it.immediate;
    addr = a + imm;
    idx = addr[mle_pkg::MemAw-1:0];
    r = '0;
    case (it.opcode)
      mle_pkg::OpRtype: begin
        case (it.function_code)
          mle_pkg::FnAdd:  regs_q[it.dest_reg] = a + b;
          mle_pkg::FnSub:  regs_q[it.dest_reg] = a - b;
          mle_pkg::FnAnd:  regs_q[it.dest_reg] = a & b;
          mle_pkg::FnOr:   regs_q[it.dest_reg] = a | b;
          mle_pkg::FnXor:  regs_q[it.dest_reg] = a ^ b;
          mle_pkg::FnMult: regs_q[it.dest_reg] = a * b;
          mle_pkg::FnDiv: begin
            if (b == 32'd0) r.fault = mle_pkg::FaultDiv0;
            else regs_q[it.dest_reg] = signed_quotient(a, b);
          end
          mle_pkg::FnSll: regs_q[it.dest_reg] = b << it.shift_amount;
          mle_pkg::FnSrl: regs_q[it.dest_reg] = b >> it.shift_amount;
          mle_pkg::FnJr: begin
            r.jump_taken = 1'b1;
            r.jump_target = a;
          end
          default: r.fault = mle_pkg::FaultOp;
        endcase
      end
      mle_pkg::OpAddi: regs_q[it.second_reg] = a + imm;
      mle_pkg::OpAndi: regs_q[it.second_reg] = a & imm;
      mle_pkg::OpOri:  regs_q[it.second_reg] = a | imm;
      mle_pkg::OpLw: begin
        if (addr >= mle_pkg::MemWords) r.fault = mle_pkg::FaultAddr;
        else regs_q[it.second_reg] = mem_q[idx];
      end
      mle_pkg::OpSw: begin
        if (addr >= mle_pkg::MemWords) r.fault = mle_pkg::FaultAddr;
        else begin
          mem_q[idx] = b;
          if (!mem_written[idx]) written_addrs.push_back(addr);
          mem_written[idx] = 1'b1;
        end
      end
      mle_pkg::OpBeq: if (a == b) begin r.jump_taken = 1'b1; r.jump_target = imm; end
      mle_pkg::OpBne: if (a != b) begin r.jump_taken = 1'b1; r.jump_target = imm; end
      mle_pkg::OpBgtz:
        if ($signed(a) > 0) begin r.jump_taken = 1'b1; r.jump_target = imm; end
      mle_pkg::OpBltz:
        if ($signed(a) < 0) begin r.jump_taken = 1'b1; r.jump_target = imm; end
      mle_pkg::OpJ: begin
        r.jump_taken = 1'b1;
        r.jump_target = imm;
      end
      mle_pkg::OpJal: begin
        r.jump_taken = 1'b1;
        r.jump_target = imm;
        regs_q[31] = it.pc_value;
      end
      mle_pkg::OpIn: regs_q[it.src_reg] = it.in_value;
      mle_pkg::OpOut: begin
        r.out_valid = 1'b1;
        r.out_value = a;
      end
      mle_pkg::OpHalt: r.halted = 1'b1;
      default: r.fault = mle_pkg::FaultOp;
    endcase
    return r;
  endfunction

  // Build an item with random field content on every field.
  function automatic mle_pkg::item_t random_fields();
    mle_pkg::item_t it;
    it.opcode = 7'($urandom);
    it.dest_reg = 5'($urandom);
    it.src_reg = 5'($urandom);
    it.second_reg = 5'($urandom);
    it.shift_amount = 5'($urandom);
    it.function_code = 7'($urandom);
    it.immediate = $urandom;
    it.pc_value = $urandom;
    it.in_value = $urandom;
    return it;
  endfunction

  // Pick an interesting 32-bit value: extremes, small values or full random.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // Make a random item that never loads a word that was never stored.
  function automatic mle_pkg::item_t random_item();
    mle_pkg::item_t it;
    int sel;
    logic [31:0] target;
    it = random_fields();
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      // noise: any opcode but LW and any function code, unknown ones included
      if (it.opcode == mle_pkg::OpLw) it.opcode = mle_pkg::OpHalt;
      if (it.opcode == mle_pkg::OpRtype && it.function_code == mle_pkg::FnDiv
          && $urandom_range(0, 1))
        it.function_code = 7'd99;
    end else if (sel < 30) begin
      case ($urandom_range(0, 9))
        0: it.function_code = mle_pkg::FnAdd;
        1: it.function_code = mle_pkg::FnSub;
        2: it.function_code = mle_pkg::FnAnd;
        3: it.function_code = mle_pkg::FnOr;
        4: it.function_code = mle_pkg::FnXor;
        5: it.function_code = mle_pkg::FnMult;
        6: it.function_code = mle_pkg::FnDiv;
        7: it.function_code = mle_pkg::FnSll;
        8: it.function_code = mle_pkg::FnSrl;
        default: it.function_code = mle_pkg::FnJr;
      endcase
      it.opcode = mle_pkg::OpRtype;
    end else if (sel < 45) begin
      it.opcode = mle_pkg::OpIn;
      it.in_value = pick_value();
    end else if (sel < 55) begin
      case ($urandom_range(0, 2))
        0: it.opcode = mle_pkg::OpAddi;
        1: it.opcode = mle_pkg::OpAndi;
        default: it.opcode = mle_pkg::OpOri;
      endcase
      it.immediate = pick_value();
    end else if (sel < 70) begin
      // store, mostly in range; offset chosen so the address lands where wanted
      it.opcode = mle_pkg::OpSw;
      if ($urandom_range(0, 5) == 0) target = pick_value() | 32'h0001_0000;
      else target = ($urandom_range(0, 3) == 0) ? mle_pkg::MemWords - 1
                                                 : $urandom_range(0, 63);
      it.immediate = target - regs_q[it.src_reg];
    end else if (sel < 82) begin
      it.opcode = mle_pkg::OpLw;
      if (written_addrs.size() == 0 || $urandom_range(0, 5) == 0)
        target = mle_pkg::MemWords + $urandom_range(0, 1000) + ($urandom_range(0, 1) << 31);
      else target = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      it.immediate = target - regs_q[it.src_reg];
    end else if (sel < 94) begin
      case ($urandom_range(0, 5))
        0: it.opcode = mle_pkg::OpBeq;
        1: it.opcode = mle_pkg::OpBne;
        2: it.opcode = mle_pkg::OpBgtz;
        3: it.opcode = mle_pkg::OpBltz;
        4: it.opcode = mle_pkg::OpJ;
        default: it.opcode = mle_pkg::OpJal;
      endcase
      if ($urandom_range(0, 1)) it.second_reg = it.src_reg;
    end else if (sel < 98) begin
      it.opcode = mle_pkg::OpOut;
    end else begin
      it.opcode = mle_pkg::OpHalt;
    end
    return it;
  endfunction

  // Directed table: the expected result is typed in where obvious, else predicted.
  typedef struct {
    mle_pkg::item_t   it;
    bit               fixed;
    mle_pkg::result_t res;
  } row_t;

  row_t directed_rows [$];

  function automatic mle_pkg::item_t mk(logic [6:0] op, logic [6:0] fn, logic [4:0] rd,
                                        logic [4:0] rs, logic [4:0] rt, logic [4:0] sh,
                                        logic [31:0] imm, logic [31:0] pc,
                                        logic [31:0] inv);
    mle_pkg::item_t it;
    it.opcode = op;
    it.function_code = fn;
    it.dest_reg = rd;
    it.src_reg = rs;
    it.second_reg = rt;
    it.shift_amount = sh;
    it.immediate = imm;
    it.pc_value = pc;
    it.in_value = inv;
    return it;
  endfunction

  function automatic mle_pkg::result_t rs_of(logic jt, logic [31:0] tgt, logic ov,
                                             logic [31:0] val, logic h, logic [1:0] f);
    mle_pkg::result_t r;
    r.jump_taken = jt;
    r.jump_target = tgt;
    r.out_valid = ov;
    r.out_value = val;
    r.halted = h;
    r.fault = f;
    return r;
  endfunction

  task automatic add_row(mle_pkg::item_t it, bit fixed, mle_pkg::result_t res);
    row_t row;
    row.it = it;
    row.fixed = fixed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  task automatic build_table();
    // after reset every register reads zero
    add_row(mk(mle_pkg::OpOut, 7'd0, 5'd0, 5'd31, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0), 1,
            rs_of(0, 0, 1, 32'd0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpIn, 7'd0, 5'd0, 5'd1, 5'd0, 5'd0, 32'd0, 32'd0, 32'h8000_0000), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpIn, 7'd0, 5'd0, 5'd2, 5'd0, 5'd0, 32'd0, 32'd0, 32'hffff_ffff), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpIn, 7'd0, 5'd0, 5'd3, 5'd0, 5'd0, 32'd0, 32'd0, 32'h7fff_ffff),
            0, '0);
    add_row(mk(mle_pkg::OpOut, 7'd0, 5'd0, 5'd1, 5'd0, 5'd0, 32'd0, 32'd0, 32'd0), 1,
            rs_of(0, 0, 1, 32'h8000_0000, 0, mle_pkg::FaultNone));
    // divide overflow and divide by zero (register 4 still zero)
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnDiv, 5'd5, 5'd1, 5'd2, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnDiv, 5'd6, 5'd1, 5'd4, 5'd0, 0, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultDiv0));
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnAdd, 5'd7, 5'd1, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnSub, 5'd8, 5'd1, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnAnd, 5'd9, 5'd2, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnOr, 5'd10, 5'd1, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnXor, 5'd11, 5'd2, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnMult, 5'd12, 5'd3, 5'd3, 5'd0, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnSll, 5'd13, 5'd0, 5'd2, 5'd31, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnSrl, 5'd14, 5'd0, 5'd2, 5'd31, 0, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpRtype, mle_pkg::FnJr, 5'd0, 5'd2, 5'd0, 5'd0, 0, 0, 0), 1,
            rs_of(1, 32'hffff_ffff, 0, 0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpRtype, 7'd127, 5'd0, 5'd0, 5'd0, 5'd0, 0, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultOp));
    add_row(mk(7'd100, 7'd0, 5'd0, 5'd0, 5'd0, 5'd0, 0, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultOp));
    // memory: top word, then out of range through a negative sum
    add_row(mk(mle_pkg::OpSw, 7'd0, 5'd0, 5'd0, 5'd3, 5'd0, mle_pkg::MemWords - 1, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpLw, 7'd0, 5'd0, 5'd0, 5'd15, 5'd0, mle_pkg::MemWords - 1, 0, 0),
            0, '0);
    add_row(mk(mle_pkg::OpSw, 7'd0, 5'd0, 5'd2, 5'd3, 5'd0, 32'd0, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultAddr));
    add_row(mk(mle_pkg::OpLw, 7'd0, 5'd0, 5'd0, 5'd15, 5'd0, mle_pkg::MemWords, 0, 0), 1,
            rs_of(0, 0, 0, 0, 0, mle_pkg::FaultAddr));
    add_row(mk(mle_pkg::OpAddi, 7'd0, 5'd0, 5'd3, 5'd16, 5'd0, 32'd1, 0, 0), 0, '0);
    add_row(mk(mle_pkg::OpJal, 7'd0, 5'd0, 5'd0, 5'd0, 5'd0, 32'h8000_0000, 32'hffff_ffff,
               0), 1, rs_of(1, 32'h8000_0000, 0, 0, 0, mle_pkg::FaultNone));
    add_row(mk(mle_pkg::OpHalt, 7'd0, 5'd0, 5'd0, 5'd0, 5'd0, 0, 0, 0), 1,
            rs_of(0, 0, 0, 0, 1, mle_pkg::FaultNone));
  endtask

  // Sender: a single transfer, valid held until accepted.
  task automatic send_item(mle_pkg::item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    in_ch.data <= random_fields();
    @(posedge clk);
  endtask

  int burst_left = 0;

  // Random gap handling between bursts of back-to-back transfers.
  task automatic maybe_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    repeat (gap) idle_sender();
  endtask

  // Expectations are pushed when the item is presented, before its result can appear.
  task automatic issue(mle_pkg::item_t it, bit fixed, mle_pkg::result_t res);
    mle_pkg::result_t predicted;
    predicted = execute_item(it);
    if (fixed && predicted != res) begin
      $error("table row disagrees with predictor for opcode %0d", it.opcode);
      errors++;
    end
    expected_results.push_back(fixed ? res : predicted);
    send_item(it);
  endtask

  // Receiver: stall pattern made of phases, some with no stalls at all.
  int stall_mode = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_phase <= $urandom_range(10, 60);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 0);
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= (stall_phase % 5 != 0);
      endcase
    end
  end

  // Result checker: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    mle_pkg::result_t want;
    mle_pkg::result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (got.fault != mle_pkg::FaultNone) faults_seen++;
      if (got.jump_taken) jumps_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.jump_taken !== want.jump_taken) begin
          $error("jump_taken expected %0h actual %0h", want.jump_taken, got.jump_taken);
          errors++;
        end
        if (got.jump_target !== want.jump_target) begin
          $error("jump_target expected %0h actual %0h", want.jump_target, got.jump_target);
          errors++;
        end
        if (got.out_valid !== want.out_valid) begin
          $error("out_valid expected %0h actual %0h", want.out_valid, got.out_valid);
          errors++;
        end
        if (got.out_value !== want.out_value) begin
          $error("out_value expected %0h actual %0h", want.out_value, got.out_value);
          errors++;
        end
        if (got.halted !== want.halted) begin
          $error("halted expected %0h actual %0h", want.halted, got.halted);
          errors++;
        end
        if (got.fault !== want.fault) begin
          $error("fault expected %0h actual %0h", want.fault, got.fault);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: %0d cycles with no transfer", quiet_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < 32; i++) regs_q[i] = '0;
    for (int i = 0; i < mle_pkg::MemWords; i++) begin
      mem_q[i] = '0;
      mem_written[i] = 1'b0;
    end
    build_table();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, walked row by row with gaps between some rows.
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].res);
      if (i % 4 == 3) idle_sender();
    end

    // Hold the sender until every expected result has come back.
    idle_sender();
    while (expected_results.size() != 0) @(posedge clk);

    // Random programs in bursts.
    for (int n = 0; n < 500; n++) begin
      maybe_gap();
      issue(random_item(), 0, '0);
      if (n == 250) begin
        idle_sender();
        while (expected_results.size() != 0) @(posedge clk);
      end
    end
    idle_sender();

    // Drain, then allow for the slowest operation's latency.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d items, %0d results, %0d faults, %0d jumps",
             items_sent, results_seen, faults_seen, jumps_seen);
    $display("all operations, fault codes and memory bounds exercised under random stalls");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
